// ----- design/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pngu_pkg.sv -----
// Shared types and constants for the PNG scanline unfilter.
package pngu_pkg;

    localparam int MAX_ROW_BYTES_DEF   = 16384;
    localparam int MAX_PIXEL_BYTES_DEF = 8;

    localparam int ROW_BYTES_W   = 15;
    localparam int PIXEL_BYTES_W = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_BYTES,
        REG_PIXEL_BYTES
    } pngu_reg_t;

    typedef enum logic [2:0] {
        FILT_NONE,
        FILT_SUB,
        FILT_UP,
        FILT_AVG,
        FILT_PAETH
    } pngu_filt_t;

    typedef struct packed {
        logic       valid;
        logic       err;
        logic       first_row;
        logic       have_left;
        logic       row_end;
        pngu_filt_t kind;
        logic [7:0] sample;
    } pngu_item_t;

endpackage

// ----- design/pngu_ram.sv -----
// Generic simple dual-port RAM with registered read.
module pngu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/pngu_ctrl.sv -----
// Stream control: filter byte parsing, column tracking, line store read ahead.
module pngu_ctrl #(
    parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           data_byte,
    input  logic                                 image_start,
    input  logic [$clog2(MAX_ROW_BYTES):0]       row_bytes_eff,
    input  logic [pngu_pkg::PIXEL_BYTES_W-1:0]   pixel_bytes_eff,
    input  logic                                 item_take,
    output logic                                 rd_en,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]     rd_addr,
    output pngu_pkg::pngu_item_t                 item,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]     item_col
);

    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int CMP_W  = ADDR_W + 1;

    logic [ADDR_W-1:0]    col_reg, col_next;
    pngu_pkg::pngu_filt_t kind_reg, kind_next;
    logic                 await_reg, await_next;
    logic                 first_reg, first_next;
    logic                 hold_reg, hold_next;
    pngu_pkg::pngu_item_t item_reg, item_next;
    logic [ADDR_W-1:0]    item_col_reg, item_col_next;

    logic              accept;
    logic              await_eff;
    logic              hold_eff;
    logic              first_eff;
    logic [ADDR_W-1:0] col_eff;
    logic [CMP_W-1:0]  col_inc;
    logic              is_row_end;
    logic              have_left;
    logic              bad;
    logic              produce;

    assign in_ready = !item_reg.valid || item_take;

    always_comb
    begin
        accept     = in_valid && in_ready;
        await_eff  = image_start || await_reg;
        hold_eff   = !image_start && hold_reg;
        first_eff  = image_start || first_reg;
        col_eff    = image_start ? '0 : col_reg;
        col_inc    = {1'b0, col_eff} + CMP_W'(1);
        is_row_end = col_inc >= row_bytes_eff;
        have_left  = {1'b0, col_eff} >= CMP_W'(pixel_bytes_eff);
        bad        = data_byte > 8'(pngu_pkg::FILT_PAETH);

        col_next      = col_reg;
        kind_next     = kind_reg;
        await_next    = await_reg;
        first_next    = first_reg;
        hold_next     = hold_reg;
        produce       = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = col_eff;
        item_col_next = item_col_reg;

        item_next = item_reg;

        if (accept)
        begin
            col_next   = col_eff;
            await_next = await_eff;
            first_next = first_eff;
            hold_next  = hold_eff;
            if (!hold_eff)
            begin
                if (await_eff)
                begin
                    col_next = '0;
                    if (bad)
                    begin
                        hold_next = 1'b1;
                        produce   = 1'b1;
                    end
                    else
                    begin
                        kind_next  = pngu_pkg::pngu_filt_t'(data_byte[2:0]);
                        await_next = 1'b0;
                    end
                end
                else
                begin
                    produce = 1'b1;
                    rd_en   = 1'b1;
                    if (is_row_end)
                    begin
                        col_next   = '0;
                        await_next = 1'b1;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        col_next = col_inc[ADDR_W-1:0];
                    end
                end
            end
        end

        if (produce)
        begin
            item_next.valid     = 1'b1;
            item_next.err       = await_eff;
            item_next.first_row = first_eff;
            item_next.have_left = have_left;
            item_next.row_end   = is_row_end && !await_eff;
            item_next.kind      = kind_reg;
            item_next.sample    = data_byte;
            item_col_next       = col_eff;
        end
        else if (item_take)
        begin
            item_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            kind_reg  <= pngu_pkg::FILT_NONE;
            await_reg <= 1'b1;
            first_reg <= 1'b1;
            hold_reg  <= 1'b0;
            item_reg  <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            kind_reg  <= kind_next;
            await_reg <= await_next;
            first_reg <= first_next;
            hold_reg  <= hold_next;
            item_reg  <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_col_reg <= item_col_next;
    end

    assign item     = item_reg;
    assign item_col = item_col_reg;

endmodule

// ----- design/pngu_recon.sv -----
// Reconstruction stage: predictor, line store write back, neighbor history, output register.
module pngu_recon #(
    parameter int MAX_ROW_BYTES   = pngu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pngu_pkg::pngu_item_t                 item,
    input  logic [$clog2(MAX_ROW_BYTES)-1:0]     item_col,
    input  logic [7:0]                           rd_data,
    input  logic [pngu_pkg::PIXEL_BYTES_W-1:0]   pixel_bytes_eff,
    output logic                                 item_take,
    output logic                                 wr_en,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]     wr_addr,
    output logic [7:0]                           wr_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [7:0]                           pixel_byte,
    output logic                                 row_end,
    output logic                                 bad_filter
);

    localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [7:0] left_reg   [MAX_PIXEL_BYTES];
    logic [7:0] left_next  [MAX_PIXEL_BYTES];
    logic [7:0] upleft_reg [MAX_PIXEL_BYTES];
    logic [7:0] upleft_next[MAX_PIXEL_BYTES];

    logic       out_valid_reg, out_valid_next;
    logic [7:0] pixel_reg, pixel_next;
    logic       row_end_reg, row_end_next;
    logic       bad_reg, bad_next;

    logic [PIX_IDX_W-1:0] pix_idx;
    logic [7:0]           a;
    logic [7:0]           b;
    logic [7:0]           c;
    logic [8:0]           sum_ab;
    logic signed [9:0]    d_bc;
    logic signed [9:0]    d_ac;
    logic signed [9:0]    d_abc;
    logic [9:0]           pa;
    logic [9:0]           pb;
    logic [9:0]           pc;
    logic [7:0]           paeth;
    logic [7:0]           pred;
    logic [7:0]           v;

    always_comb
    begin
        pix_idx = PIX_IDX_W'(pixel_bytes_eff - 4'd1);
        a       = item.have_left ? left_reg[pix_idx] : 8'd0;
        c       = item.have_left ? upleft_reg[pix_idx] : 8'd0;
        b       = item.first_row ? 8'd0 : rd_data;

        sum_ab = {1'b0, a} + {1'b0, b};
        d_bc   = $signed({2'b00, b}) - $signed({2'b00, c});
        d_ac   = $signed({2'b00, a}) - $signed({2'b00, c});
        d_abc  = $signed({2'b00, sum_ab[7:0]}) + $signed({1'b0, sum_ab[8], 8'd0})
                 - $signed({1'b0, c, 1'b0});
        pa     = d_bc[9] ? 10'(-d_bc) : 10'(d_bc);
        pb     = d_ac[9] ? 10'(-d_ac) : 10'(d_ac);
        pc     = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);

        if (pa <= pb && pa <= pc)
        begin
            paeth = a;
        end
        else if (pb <= pc)
        begin
            paeth = b;
        end
        else
        begin
            paeth = c;
        end

        case (item.kind)
            pngu_pkg::FILT_SUB:   pred = a;
            pngu_pkg::FILT_UP:    pred = b;
            pngu_pkg::FILT_AVG:   pred = sum_ab[8:1];
            pngu_pkg::FILT_PAETH: pred = paeth;
            default:              pred = 8'd0;
        endcase

        v = item.sample + pred;
    end

    always_comb
    begin
        item_take = item.valid && (!out_valid_reg || out_ready);
        wr_en     = item_take && !item.err;
        wr_addr   = item_col;
        wr_data   = v;

        out_valid_next = out_valid_reg;
        pixel_next     = pixel_reg;
        row_end_next   = row_end_reg;
        bad_next       = bad_reg;

        if (item_take)
        begin
            out_valid_next = 1'b1;
            pixel_next     = item.err ? 8'd0 : v;
            row_end_next   = item.row_end && !item.err;
            bad_next       = item.err;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        for (int i = 0; i < MAX_PIXEL_BYTES; i++)
        begin
            left_next[i]   = left_reg[i];
            upleft_next[i] = upleft_reg[i];
        end
        if (wr_en)
        begin
            left_next[0]   = v;
            upleft_next[0] = b;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++)
            begin
                left_next[i]   = left_reg[i-1];
                upleft_next[i] = upleft_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg   <= pixel_next;
        row_end_reg <= row_end_next;
        bad_reg     <= bad_next;
        left_reg    <= left_next;
        upleft_reg  <= upleft_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_reg;
    assign row_end    = row_end_reg;
    assign bad_filter = bad_reg;

endmodule

// ----- design/png_scanline_unfilter.sv -----
// PNG scanline unfilter top level: configuration registers and stage wiring.
//
// Input channel (in_valid/in_ready) takes one inflated stream byte per request,
// with image_start marking the filter byte that opens a new image. Filter bytes
// and bytes dropped after a bad filter type give no result; every sample byte
// gives one reconstructed byte, and an unknown filter type gives one result
// with bad_filter set.
// Output channel (out_valid/out_ready) carries pixel_byte, row_end, bad_filter.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// row_bytes (index 0) and pixel_bytes (index 1); cfg_ready is always high.
// The accepting edge registers the request and the line store read; the
// predictor result is then loaded into the output register once it is free.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single line store read and write port pair.
// Reset clears row and image state; the line store holds nothing valid until
// the first row of an image is written. When the receiver stalls, one result
// waits in the output register and one more in the stage behind it; after
// that in_ready drops until the output is taken.
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = pngu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       data_byte,
    input  logic                             image_start,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       pixel_byte,
    output logic                             row_end,
    output logic                             bad_filter,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pngu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int CMP_W  = ADDR_W + 1;
    localparam int RBW    = (CMP_W > pngu_pkg::ROW_BYTES_W) ? CMP_W : pngu_pkg::ROW_BYTES_W;

    logic [pngu_pkg::ROW_BYTES_W-1:0]   row_bytes_reg, row_bytes_next;
    logic [pngu_pkg::PIXEL_BYTES_W-1:0] pixel_bytes_reg, pixel_bytes_next;

    logic [RBW-1:0]                     rb_wide;
    logic [CMP_W-1:0]                   row_bytes_eff;
    logic [pngu_pkg::PIXEL_BYTES_W-1:0] pixel_bytes_eff;

    pngu_pkg::pngu_item_t item;
    logic [ADDR_W-1:0]    item_col;
    logic                 item_take;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [7:0]           rd_data;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [7:0]           wr_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        row_bytes_next   = row_bytes_reg;
        pixel_bytes_next = pixel_bytes_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pngu_pkg::REG_ROW_BYTES:
                begin
                    row_bytes_next = cfg_data[pngu_pkg::ROW_BYTES_W-1:0];
                end
                pngu_pkg::REG_PIXEL_BYTES:
                begin
                    pixel_bytes_next = cfg_data[pngu_pkg::PIXEL_BYTES_W-1:0];
                end
                default:
                begin
                    row_bytes_next = row_bytes_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg   <= pngu_pkg::ROW_BYTES_W'(1);
            pixel_bytes_reg <= pngu_pkg::PIXEL_BYTES_W'(1);
        end
        else
        begin
            row_bytes_reg   <= row_bytes_next;
            pixel_bytes_reg <= pixel_bytes_next;
        end
    end

    always_comb
    begin
        rb_wide = RBW'(row_bytes_reg);
        if (rb_wide == '0)
        begin
            rb_wide = RBW'(1);
        end
        else if (rb_wide > RBW'(MAX_ROW_BYTES))
        begin
            rb_wide = RBW'(MAX_ROW_BYTES);
        end
        row_bytes_eff = CMP_W'(rb_wide);

        pixel_bytes_eff = pixel_bytes_reg;
        if (pixel_bytes_reg == '0)
        begin
            pixel_bytes_eff = pngu_pkg::PIXEL_BYTES_W'(1);
        end
        else if (pixel_bytes_reg > pngu_pkg::PIXEL_BYTES_W'(MAX_PIXEL_BYTES))
        begin
            pixel_bytes_eff = pngu_pkg::PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
        end
    end

    pngu_ctrl #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .image_start     (image_start),
        .row_bytes_eff   (row_bytes_eff),
        .pixel_bytes_eff (pixel_bytes_eff),
        .item_take       (item_take),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .item            (item),
        .item_col        (item_col)
    );

    pngu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pngu_recon #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_recon (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item),
        .item_col        (item_col),
        .rd_data         (rd_data),
        .pixel_bytes_eff (pixel_bytes_eff),
        .item_take       (item_take),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_byte      (pixel_byte),
        .row_end         (row_end),
        .bad_filter      (bad_filter)
    );

endmodule

// ----- design/pngu_checker.sv -----
// Port-level checker for the PNG scanline unfilter, bound to the top level.
`include "assert_macros.svh"

module pngu_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [7:0]                       pixel_byte,
    input logic                             row_end,
    input logic                             bad_filter
);

    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped")
    `CHK_IMPLIES(a_err_clean, clk, rst_n, out_valid && bad_filter, pixel_byte == 8'd0 && !row_end, "error result not clean")
    `CHK_IMPLIES(a_rose_src, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without request")
    `CHK_IMPLIES(a_stall_only, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled without output stall")

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (.*);

// ----- sim/tb_png_scanline_unfilter.sv -----
// Self-checking testbench for the PNG scanline unfilter: predicts reconstructed bytes.
`timescale 1ns / 100ps

module tb_png_scanline_unfilter;

    localparam int MAX_ROW = pngu_pkg::MAX_ROW_BYTES_DEF;
    localparam int MAX_PIX = pngu_pkg::MAX_PIXEL_BYTES_DEF;
    localparam logic [7:0] BAD_FILTER_LOW = 8'(pngu_pkg::FILT_PAETH) + 8'd1;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } stream_req_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
        logic       bad;
    } pixel_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [7:0]                      data_byte = 8'h00;
    logic                            image_start = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [7:0]                      pixel_byte;
    logic                            row_end;
    logic                            bad_filter;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    pngu_pkg::pngu_reg_t             cfg_index = pngu_pkg::REG_ROW_BYTES;
    logic [pngu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    stream_req_t   pending_reqs[$];
    pixel_result_t result_q[$];

    // unfilter state as seen from outside
    logic [7:0]           above_row [0:MAX_ROW-1];
    logic [7:0]           left_hist [0:MAX_PIX-1];
    logic [7:0]           up_left_hist [0:MAX_PIX-1];
    int                   col_pos = 0;
    pngu_pkg::pngu_filt_t row_filter = pngu_pkg::FILT_NONE;
    bit                   want_filter = 1'b1;
    bit                   in_first_row = 1'b1;
    bit                   dropping = 1'b0;
    logic [14:0]          cfg_row_len = 15'd1;
    logic [3:0]           cfg_pixel_dist = 4'd1;
    int                   store_high = 0;

    bit in_fire_seen = 1'b0;
    bit holding = 1'b0;
    bit in_idle_on = 1'b1;
    bit out_idle_on = 1'b1;
    int gap_left = 0;
    int stall_left = 0;
    int reqs_queued = 0;
    int reqs_taken = 0;
    int results_seen = 0;
    int rows_closed = 0;
    int bad_seen = 0;
    int reg_writes = 0;
    int mismatch_count = 0;

    int row_set [0:11] = '{0, 2, 5, 7, 1, 12, 4, 9, 3, 6, 16, 8};
    int pix_set [0:11] = '{0, 9, 3, 8, 15, 4, 1, 6, 2, 5, 7, 11};

    png_scanline_unfilter uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .image_start (image_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_byte  (pixel_byte),
        .row_end     (row_end),
        .bad_filter  (bad_filter),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int row_len(logic [14:0] r);
        if (r == 15'd0)
        begin
            return 1;
        end
        if (r > MAX_ROW)
        begin
            return MAX_ROW;
        end
        return int'(r);
    endfunction

    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic unfilter_byte(input logic [7:0] din, input logic start);
        int rb;
        int pbw;
        int a;
        int b;
        int c;
        int p;
        int da;
        int db;
        int dc;
        int pred;
        int i;
        logic [7:0] v;
        rb = row_len(cfg_row_len);
        pbw = (cfg_pixel_dist == 4'd0) ? 1 :
              ((cfg_pixel_dist > MAX_PIX) ? MAX_PIX : int'(cfg_pixel_dist));
        if (start)
        begin
            in_first_row = 1'b1;
            dropping = 1'b0;
            want_filter = 1'b1;
            col_pos = 0;
        end
        if (dropping)
        begin
            return;
        end
        if (want_filter)
        begin
            col_pos = 0;
            for (i = 0; i < MAX_PIX; i++)
            begin
                left_hist[i] = 8'h00;
                up_left_hist[i] = 8'h00;
            end
            if (din >= BAD_FILTER_LOW)
            begin
                dropping = 1'b1;
                result_q.push_back('{8'h00, 1'b0, 1'b1});
                return;
            end
            row_filter = pngu_pkg::pngu_filt_t'(din[2:0]);
            want_filter = 1'b0;
            return;
        end
        b = in_first_row ? 0 : int'(above_row[col_pos]);
        a = (col_pos >= pbw) ? int'(left_hist[pbw-1]) : 0;
        c = (col_pos >= pbw) ? int'(up_left_hist[pbw-1]) : 0;
        case (row_filter)
            pngu_pkg::FILT_SUB:   pred = a;
            pngu_pkg::FILT_UP:    pred = b;
            pngu_pkg::FILT_AVG:   pred = (a + b) >> 1;
            pngu_pkg::FILT_PAETH:
            begin
                p = a + b - c;
                da = (p > a) ? p - a : a - p;
                db = (p > b) ? p - b : b - p;
                dc = (p > c) ? p - c : c - p;
                if (da <= db && da <= dc)
                begin
                    pred = a;
                end
                else if (db <= dc)
                begin
                    pred = b;
                end
                else
                begin
                    pred = c;
                end
            end
            default:    pred = 0;
        endcase
        v = din + pred[7:0];
        above_row[col_pos] = v;
        for (i = MAX_PIX - 1; i > 0; i--)
        begin
            left_hist[i] = left_hist[i-1];
            up_left_hist[i] = up_left_hist[i-1];
        end
        left_hist[0] = v;
        up_left_hist[0] = b[7:0];
        col_pos++;
        if (col_pos > store_high)
        begin
            store_high = col_pos;
        end
        if (col_pos >= rb)
        begin
            result_q.push_back('{v, 1'b1, 1'b0});
            col_pos = 0;
            want_filter = 1'b1;
            in_first_row = 1'b0;
        end
        else
        begin
            result_q.push_back('{v, 1'b0, 1'b0});
        end
    endtask

    // check the output first, then predict the request taken at the same edge
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result, pixel_byte %02h", pixel_byte));
            end
            else
            begin
                want = result_q.pop_front();
                if (pixel_byte !== want.pixel)
                begin
                    flag_mismatch($sformatf("pixel_byte %02h, predicted %02h",
                                            pixel_byte, want.pixel));
                end
                if (row_end !== want.last)
                begin
                    flag_mismatch($sformatf("row_end %b, predicted %b", row_end, want.last));
                end
                if (bad_filter !== want.bad)
                begin
                    flag_mismatch($sformatf("bad_filter %b, predicted %b",
                                            bad_filter, want.bad));
                end
                results_seen++;
                if (want.last)
                begin
                    rows_closed++;
                end
                if (want.bad)
                begin
                    bad_seen++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            unfilter_byte(data_byte, image_start);
            reqs_taken++;
            in_fire_seen = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        stream_req_t nxt;
        if (rst_n)
        begin
            if (in_fire_seen)
            begin
                in_fire_seen = 1'b0;
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_reqs.size() != 0)
                begin
                    nxt = pending_reqs.pop_front();
                    data_byte <= nxt.data;
                    image_start <= nxt.start;
                    holding = 1'b1;
                    gap_left = pick_gap(in_idle_on);
                end
            end
            in_valid <= holding;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap(out_idle_on);
                end
            end
        end
    end

    task automatic enqueue(input logic [7:0] d, input logic s);
        pending_reqs.push_back('{d, s});
        reqs_queued++;
    endtask

    task automatic queue_row(input logic start, input int len);
        int k;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            enqueue(8'($urandom_range(int'(BAD_FILTER_LOW), 255)), start);
        end
        else
        begin
            enqueue(8'($urandom_range(int'(pngu_pkg::FILT_NONE), int'(pngu_pkg::FILT_PAETH))),
                    start);
        end
        for (k = 0; k < len; k++)
        begin
            r = $urandom_range(0, 99);
            enqueue((r < 10) ? 8'h00 : ((r < 20) ? 8'hFF : 8'($urandom_range(0, 255))), 1'b0);
        end
    endtask

    task automatic queue_image(input int len);
        int n;
        int k;
        int l;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
        begin
            l = len;
            if (k == n - 1 && $urandom_range(0, 5) == 0)
            begin
                l = $urandom_range(0, len - 1);
            end
            queue_row(k == 0, l);
        end
    endtask

    task automatic queue_phase(input int target, input bit force_start);
        int base;
        int len;
        int r;
        int k;
        base = reqs_queued;
        len = row_len(cfg_row_len);
        if (force_start)
        begin
            queue_image(len);
        end
        while (reqs_queued - base < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                queue_image(len);
            end
            else if (r < 88)
            begin
                queue_row(1'b0, len);
            end
            else
            begin
                for (k = $urandom_range(1, 6); k > 0; k--)
                begin
                    enqueue(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
            end
        end
    endtask

    // hold until every request is taken and every result is back
    task automatic settle();
        while (reqs_taken != reqs_queued || result_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input pngu_pkg::pngu_reg_t idx,
                             input logic [pngu_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == pngu_pkg::REG_ROW_BYTES)
        begin
            cfg_row_len = val[14:0];
        end
        else
        begin
            cfg_pixel_dist = val[3:0];
        end
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int ph;
        int k;
        int guard;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        enqueue(8'(pngu_pkg::FILT_NONE), 1'b1);
        enqueue(8'hFF, 1'b0);
        enqueue(8'(pngu_pkg::FILT_UP), 1'b0);
        enqueue(8'h01, 1'b0);
        enqueue(8'(pngu_pkg::FILT_AVG), 1'b0);
        enqueue(8'hFE, 1'b0);
        enqueue(8'(pngu_pkg::FILT_PAETH), 1'b0);
        enqueue(8'h00, 1'b0);
        enqueue(8'(pngu_pkg::FILT_SUB), 1'b0);
        enqueue(8'h55, 1'b0);
        enqueue(BAD_FILTER_LOW, 1'b0);
        enqueue(8'(pngu_pkg::FILT_UP), 1'b0);
        enqueue(8'h00, 1'b0);
        enqueue(8'hFF, 1'b1);
        enqueue(8'(pngu_pkg::FILT_PAETH), 1'b1);
        enqueue(8'h80, 1'b0);
        settle();

        for (ph = 0; ph < 12; ph++)
        begin
            write_reg(pngu_pkg::REG_ROW_BYTES, 15'(row_set[ph]));
            write_reg(pngu_pkg::REG_PIXEL_BYTES, {11'($urandom_range(0, 2047)), 4'(pix_set[ph])});
            in_idle_on = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            queue_phase(50, row_len(cfg_row_len) > store_high);
            settle();
        end

        // widest row setting, cut short by a new image
        write_reg(pngu_pkg::REG_ROW_BYTES, 15'h7FFF);
        write_reg(pngu_pkg::REG_PIXEL_BYTES, 15'd15);
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        enqueue(8'(pngu_pkg::FILT_PAETH), 1'b1);
        for (k = 0; k < 200; k++)
        begin
            enqueue(8'($urandom_range(0, 255)), 1'b0);
        end
        enqueue(8'(pngu_pkg::FILT_NONE), 1'b1);
        for (k = 0; k < 5; k++)
        begin
            enqueue(8'($urandom_range(0, 255)), 1'b0);
        end
        settle();

        // shrink the row below the current column
        write_reg(pngu_pkg::REG_ROW_BYTES, 15'd3);
        enqueue(8'h5A, 1'b0);
        queue_phase(40, row_len(cfg_row_len) > store_high);

        guard = 0;
        while ((reqs_taken != reqs_queued || result_q.size() != 0) && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (4) @(negedge clk);
        if (reqs_taken != reqs_queued)
        begin
            flag_mismatch($sformatf("%0d stream bytes never taken", reqs_queued - reqs_taken));
        end
        if (result_q.size() != 0)
        begin
            flag_mismatch($sformatf("%0d predicted results never came out", result_q.size()));
        end
        $display("Run drove %0d stream bytes and %0d register writes, row settings up to %0d",
                 reqs_taken, reg_writes, MAX_ROW);
        $display("Checked %0d results: %0d row ends, %0d bad filter reports",
                 results_seen, rows_closed, bad_seen);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #50000000;
        $display("FAILURE");
        $finish;
    end

endmodule
